### src/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// shared constants, command codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int unsigned MAX_PROCESSES = 16;
  localparam int unsigned MAX_RESOURCES = 8;
  localparam int unsigned AMOUNT_BITS   = 16;

  localparam int unsigned PROC_W   = $clog2(MAX_PROCESSES);
  localparam int unsigned RES_W    = $clog2(MAX_RESOURCES);
  localparam int unsigned CELL_W   = PROC_W + RES_W;
  localparam int unsigned CELLS    = MAX_PROCESSES * MAX_RESOURCES;
  localparam int unsigned CNT_W    = $clog2(MAX_PROCESSES + 1);
  localparam int unsigned RCNT_W   = $clog2(MAX_RESOURCES + 1);
  localparam int unsigned WORK_W   = AMOUNT_BITS + CNT_W;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = (CNT_W > RCNT_W) ? CNT_W : RCNT_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_ALLOC = 2'd0,
    CMD_WR_MAX   = 2'd1,
    CMD_WR_AVAIL = 2'd2,
    CMD_RUN      = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROCESS_COUNT  = 1'b0,
    CFG_RESOURCE_COUNT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic              load;
    logic              init;
    logic              check_begin;
    logic              rd_en;
    logic              commit;
    logic              seq_sel;
    logic [PROC_W-1:0] proc;
    logic [RES_W-1:0]  res;
  } bsc_cmd_t;

  typedef struct packed {
    logic             finished;
    logic             fit;
    logic [CNT_W-1:0] count;
  } bsc_status_t;

endpackage

### src/bsc_datapath.sv
// ----------------------------------------------------------------------------
// bsc_datapath
// claim tables, available vector, working vector, finish flags and sequence
// ----------------------------------------------------------------------------
module bsc_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bsc_pkg::bsc_cmd_t                cmd_i,
  output bsc_pkg::bsc_status_t             status_o,
  input  logic [bsc_pkg::CMD_W-1:0]        command_i,
  input  logic [bsc_pkg::PROC_W-1:0]       process_index_i,
  input  logic [bsc_pkg::RES_W-1:0]        resource_index_i,
  input  logic [bsc_pkg::AMOUNT_BITS-1:0]  amount_i,
  output logic [bsc_pkg::PROC_W-1:0]       process_id_o
);
  import bsc_pkg::*;

  logic [AMOUNT_BITS-1:0] alloc_mem [CELLS];
  logic [AMOUNT_BITS-1:0] max_mem   [CELLS];
  logic [AMOUNT_BITS-1:0] avail_q   [MAX_RESOURCES];
  logic [AMOUNT_BITS-1:0] stash_q   [MAX_RESOURCES];
  logic [WORK_W-1:0]      work_q    [MAX_RESOURCES];
  logic [PROC_W-1:0]      seq_q     [MAX_PROCESSES];

  logic [AMOUNT_BITS-1:0]   alloc_rd_q, max_rd_q;
  logic                     rd_valid_q;
  logic [RES_W-1:0]         rd_res_q;
  logic                     fit_q;
  logic [MAX_PROCESSES-1:0] finished_q;
  logic [CNT_W-1:0]         count_q;

  logic [CELL_W-1:0] wr_addr, rd_addr;
  logic [WORK_W:0]   have_sum;
  logic              row_fits;

  assign wr_addr = {process_index_i, resource_index_i};
  assign rd_addr = {cmd_i.proc, cmd_i.res};

  // table and available loads
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && command_i == CMD_WR_ALLOC) begin
      alloc_mem[wr_addr] <= amount_i;
    end
    if (cmd_i.load && command_i == CMD_WR_MAX) begin
      max_mem[wr_addr] <= amount_i;
    end
    if (cmd_i.load && command_i == CMD_WR_AVAIL) begin
      avail_q[resource_index_i] <= amount_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      alloc_rd_q <= alloc_mem[rd_addr];
      max_rd_q   <= max_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
      rd_res_q   <= '0;
    end else begin
      rd_valid_q <= cmd_i.rd_en;
      rd_res_q   <= cmd_i.res;
    end
  end

  // need fits when max <= alloc + work
  assign have_sum = {1'b0, work_q[rd_res_q]} + (WORK_W+1)'(alloc_rd_q);
  assign row_fits = (WORK_W+1)'(max_rd_q) <= have_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_q <= 1'b0;
    end else if (cmd_i.check_begin) begin
      fit_q <= 1'b1;
    end else if (rd_valid_q && !row_fits) begin
      fit_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_valid_q) begin
      stash_q[rd_res_q] <= alloc_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_RESOURCES; i++) begin
      if (cmd_i.init) begin
        work_q[i] <= WORK_W'(avail_q[i]);
      end else if (cmd_i.commit && fit_q) begin
        work_q[i] <= work_q[i] + WORK_W'(stash_q[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      finished_q <= '0;
      count_q    <= '0;
      for (int i = 0; i < MAX_PROCESSES; i++) begin
        seq_q[i] <= '0;
      end
    end else if (cmd_i.init) begin
      finished_q <= '0;
      count_q    <= '0;
      for (int i = 0; i < MAX_PROCESSES; i++) begin
        seq_q[i] <= '0;
      end
    end else if (cmd_i.commit && fit_q) begin
      finished_q[cmd_i.proc]          <= 1'b1;
      seq_q[count_q[PROC_W-1:0]]      <= cmd_i.proc;
      count_q                         <= count_q + CNT_W'(1);
    end
  end

  assign status_o.finished = finished_q[cmd_i.proc];
  assign status_o.fit      = fit_q;
  assign status_o.count    = count_q;

  assign process_id_o = cmd_i.seq_sel ? seq_q[cmd_i.proc] : '0;

endmodule

### src/bsc_ctrl.sv
// ----------------------------------------------------------------------------
// bsc_ctrl
// run sequencer: sweeps, per-process row checks, commit and result emission
// ----------------------------------------------------------------------------
module bsc_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic [bsc_pkg::CMD_W-1:0]   command_i,
  input  logic [bsc_pkg::PROC_W-1:0]  np_m1_i,
  input  logic [bsc_pkg::RES_W-1:0]   nr_m1_i,
  input  bsc_pkg::bsc_status_t        status_i,
  output bsc_pkg::bsc_cmd_t           cmd_o,
  output logic                        busy,
  output logic                        result_valid_o,
  output logic                        safe_o,
  output logic                        last_o
);
  import bsc_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b0_0000_0001,
    ST_INIT   = 9'b0_0000_0010,
    ST_SELECT = 9'b0_0000_0100,
    ST_READ   = 9'b0_0000_1000,
    ST_DRAIN  = 9'b0_0001_0000,
    ST_COMMIT = 9'b0_0010_0000,
    ST_FINISH = 9'b0_0100_0000,
    ST_EMIT   = 9'b0_1000_0000,
    ST_UNSAFE = 9'b1_0000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [PROC_W-1:0] proc_q, proc_d;
  logic [PROC_W-1:0] sweep_q, sweep_d;
  logic [RES_W-1:0]  res_q, res_d;
  logic              accept;
  logic              last_proc;
  logic [CNT_W-1:0]  np_full;

  assign accept    = start && (state_q == ST_IDLE);
  assign last_proc = (proc_q == np_m1_i);
  assign np_full   = CNT_W'(np_m1_i) + CNT_W'(1);

  always_comb begin
    state_d = state_q;
    proc_d  = proc_q;
    sweep_d = sweep_q;
    res_d   = res_q;
    cmd_o   = '0;
    cmd_o.proc = proc_q;
    cmd_o.res  = res_q;
    result_valid_o = 1'b0;
    safe_o  = 1'b0;
    last_o  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (command_i == CMD_RUN) begin
            state_d = ST_INIT;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        proc_d  = '0;
        sweep_d = '0;
        state_d = ST_SELECT;
      end
      ST_SELECT: begin
        res_d = '0;
        if (!status_i.finished) begin
          cmd_o.check_begin = 1'b1;
          state_d = ST_READ;
        end else if (last_proc) begin
          proc_d = '0;
          if (sweep_q == np_m1_i) begin
            state_d = ST_FINISH;
          end else begin
            sweep_d = sweep_q + PROC_W'(1);
          end
        end else begin
          proc_d = proc_q + PROC_W'(1);
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        res_d = res_q + RES_W'(1);
        if (res_q == nr_m1_i) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d = ST_SELECT;
        if (last_proc) begin
          proc_d = '0;
          if (sweep_q == np_m1_i) begin
            state_d = ST_FINISH;
          end else begin
            sweep_d = sweep_q + PROC_W'(1);
          end
        end else begin
          proc_d = proc_q + PROC_W'(1);
        end
      end
      ST_FINISH: begin
        proc_d  = '0;
        state_d = (status_i.count == np_full) ? ST_EMIT : ST_UNSAFE;
      end
      ST_EMIT: begin
        cmd_o.seq_sel  = 1'b1;
        result_valid_o = 1'b1;
        safe_o         = 1'b1;
        last_o         = last_proc;
        if (last_proc) begin
          state_d = ST_IDLE;
        end else begin
          proc_d = proc_q + PROC_W'(1);
        end
      end
      ST_UNSAFE: begin
        result_valid_o = 1'b1;
        last_o         = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      proc_q  <= '0;
      sweep_q <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      proc_q  <= proc_d;
      sweep_q <= sweep_d;
      res_q   <= res_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

### src/bankers_safety_check_unit.sv
// ----------------------------------------------------------------------------
// bankers_safety_check_unit
// load commands (allocation, maximum claim, available) are taken while idle and
// can follow back to back; busy stays low for them
// the worst-case run time is set by the per-resource
// table read loop (one row entry per cycle); results then come one per cycle
// results cannot be stalled; reset clears control, finish flags and sequence,
// the tables stay undefined until loaded; config reset: 16 processes, 8 resources
// ----------------------------------------------------------------------------
module bankers_safety_check_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bsc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              start,
  output logic                              busy,
  input  logic [bsc_pkg::CMD_W-1:0]         command_i,
  input  logic [bsc_pkg::PROC_W-1:0]        process_index_i,
  input  logic [bsc_pkg::RES_W-1:0]         resource_index_i,
  input  logic [bsc_pkg::AMOUNT_BITS-1:0]   amount_i,
  output logic                              result_valid_o,
  output logic [bsc_pkg::PROC_W-1:0]        process_id_o,
  output logic                              safe_o,
  output logic                              last_o
);
  import bsc_pkg::*;

  logic [CNT_W-1:0]  process_count_q;
  logic [RCNT_W-1:0] resource_count_q;
  logic [PROC_W-1:0] np_m1;
  logic [RES_W-1:0]  nr_m1;
  bsc_cmd_t          cmd;
  bsc_status_t       status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      process_count_q  <= CNT_W'(MAX_PROCESSES);
      resource_count_q <= RCNT_W'(MAX_RESOURCES);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PROCESS_COUNT:  process_count_q  <= CNT_W'(cfg_data_i);
        CFG_RESOURCE_COUNT: resource_count_q <= RCNT_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // counts saturated into their legal ranges
  always_comb begin
    if (process_count_q == '0) begin
      np_m1 = '0;
    end else if (process_count_q > CNT_W'(MAX_PROCESSES)) begin
      np_m1 = PROC_W'(MAX_PROCESSES - 1);
    end else begin
      np_m1 = PROC_W'(process_count_q - CNT_W'(1));
    end
    if (resource_count_q == '0) begin
      nr_m1 = '0;
    end else if (resource_count_q > RCNT_W'(MAX_RESOURCES)) begin
      nr_m1 = RES_W'(MAX_RESOURCES - 1);
    end else begin
      nr_m1 = RES_W'(resource_count_q - RCNT_W'(1));
    end
  end

  bsc_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .command_i      (command_i),
    .np_m1_i        (np_m1),
    .nr_m1_i        (nr_m1),
    .status_i       (status),
    .cmd_o          (cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .safe_o         (safe_o),
    .last_o         (last_o)
  );

  bsc_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .command_i        (command_i),
    .process_index_i  (process_index_i),
    .resource_index_i (resource_index_i),
    .amount_i         (amount_i),
    .process_id_o     (process_id_o)
  );

`ifndef SYNTHESIS
  a_result_only_when_busy: assert property (
    @(posedge clk_i) disable iff (!rst_ni) result_valid_o |-> busy
  ) else $error("result strobe outside a run");

  a_unsafe_is_last: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (result_valid_o && !safe_o) |-> last_o
  ) else $error("unsafe result without last mark");

  a_last_ends_run: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (result_valid_o && last_o) |=> !busy
  ) else $error("run did not end after last result");

  a_busy_from_run: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      $rose(busy) |-> $past(start && command_i == CMD_RUN)
  ) else $error("busy rose without an accepted run transaction");
`endif

endmodule

### tb/sv/bankers_safety_check_unit_tb.sv
// ----------------------------------------------------------------------------
// bankers_safety_check_unit_tb
// self-checking bench: loads allocation, claim and available entries, issues
// run commands and checks every safe sequence or unsafe verdict against a
// cycle-free predictor kept in the bench; directed cases first, then random
// traffic across several process/resource count settings and idle patterns
// ----------------------------------------------------------------------------
module bankers_safety_check_unit_tb;
  import bsc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned MAX_REPORTS = 50;

  typedef struct packed {
    logic [PROC_W-1:0] process_id;
    logic              safe;
    logic              last;
  } safety_result_t;

  logic                   clk_i            = 1'b0;
  logic                   rst_ni           = 1'b0;
  logic                   cfg_we_i         = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i      = CFG_PROCESS_COUNT;
  logic [CFG_DATA_W-1:0]  cfg_data_i       = '0;
  logic                   start            = 1'b0;
  logic                   busy;
  logic [CMD_W-1:0]       command_i        = CMD_WR_ALLOC;
  logic [PROC_W-1:0]      process_index_i  = '0;
  logic [RES_W-1:0]       resource_index_i = '0;
  logic [AMOUNT_BITS-1:0] amount_i         = '0;
  logic                   result_valid_o;
  logic [PROC_W-1:0]      process_id_o;
  logic                   safe_o;
  logic                   last_o;

  logic [AMOUNT_BITS-1:0] alloc_tbl [MAX_PROCESSES][MAX_RESOURCES];
  logic [AMOUNT_BITS-1:0] claim_tbl [MAX_PROCESSES][MAX_RESOURCES];
  logic [AMOUNT_BITS-1:0] avail_vec [MAX_RESOURCES];
  bit                     alloc_loaded [MAX_PROCESSES][MAX_RESOURCES];
  bit                     claim_loaded [MAX_PROCESSES][MAX_RESOURCES];
  bit                     avail_loaded [MAX_RESOURCES];
  logic [CNT_W-1:0]       procs_reg = CNT_W'(MAX_PROCESSES);
  logic [RCNT_W-1:0]      res_reg   = RCNT_W'(MAX_RESOURCES);

  safety_result_t pending_results [$];
  int unsigned    mismatch_count = 0;
  int unsigned    cycle_count    = 0;
  int unsigned    items_issued   = 0;
  int unsigned    idle_pct       = 0;
  int unsigned    next_gap       = 0;
  bit             start_held     = 1'b0;

  bankers_safety_check_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .start            (start),
    .busy             (busy),
    .command_i        (command_i),
    .process_index_i  (process_index_i),
    .resource_index_i (resource_index_i),
    .amount_i         (amount_i),
    .result_valid_o   (result_valid_o),
    .process_id_o     (process_id_o),
    .safe_o           (safe_o),
    .last_o           (last_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("mismatch @%0d: %s", cycle_count, msg);
  endtask

  always @(posedge clk_i) begin : check_results
    safety_result_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result pid=%0d safe=%0b last=%0b",
                                process_id_o, safe_o, last_o));
      end else begin
        want = pending_results.pop_front();
        if (process_id_o !== want.process_id)
          flag_mismatch($sformatf("process_id %0d, want %0d", process_id_o, want.process_id));
        if (safe_o !== want.safe)
          flag_mismatch($sformatf("safe %0b, want %0b", safe_o, want.safe));
        if (last_o !== want.last)
          flag_mismatch($sformatf("last %0b, want %0b", last_o, want.last));
      end
    end
  end

  function automatic int unsigned procs_in_use();
    if (procs_reg == 0) return 1;
    if (procs_reg > MAX_PROCESSES) return MAX_PROCESSES;
    return int'(procs_reg);
  endfunction

  function automatic int unsigned res_in_use();
    if (res_reg == 0) return 1;
    if (res_reg > MAX_RESOURCES) return MAX_RESOURCES;
    return int'(res_reg);
  endfunction

  // sweep np times; any unfinished process whose need fits returns its allocation
  function automatic void predict_safe_sequence();
    int unsigned       np;
    int unsigned       nr;
    int unsigned       found;
    longint            work [MAX_RESOURCES];
    bit                done [MAX_PROCESSES];
    logic [PROC_W-1:0] order [MAX_PROCESSES];
    bit                fits;
    longint            need;
    safety_result_t    item;
    np = procs_in_use();
    nr = res_in_use();
    found = 0;
    for (int r = 0; r < MAX_RESOURCES; r++) work[r] = longint'(avail_vec[r]);
    for (int p = 0; p < MAX_PROCESSES; p++) done[p] = 1'b0;
    for (int sweep = 0; sweep < np; sweep++) begin
      for (int p = 0; p < np; p++) begin
        if (!done[p]) begin
          fits = 1'b1;
          for (int r = 0; r < nr; r++) begin
            need = longint'(claim_tbl[p][r]) - longint'(alloc_tbl[p][r]);
            if (need > work[r]) fits = 1'b0;
          end
          if (fits) begin
            order[found] = PROC_W'(p);
            found++;
            for (int r = 0; r < nr; r++) work[r] += longint'(alloc_tbl[p][r]);
            done[p] = 1'b1;
          end
        end
      end
    end
    if (found < np) begin
      item.process_id = '0;
      item.safe       = 1'b0;
      item.last       = 1'b1;
      pending_results.push_back(item);
    end else begin
      for (int i = 0; i < np; i++) begin
        item.process_id = order[i];
        item.safe       = 1'b1;
        item.last       = (i + 1 == np);
        pending_results.push_back(item);
      end
    end
  endfunction

  function automatic void record_command(input cmd_e cmd, input logic [PROC_W-1:0] proc,
                                         input logic [RES_W-1:0] res,
                                         input logic [AMOUNT_BITS-1:0] amount);
    case (cmd)
      CMD_WR_ALLOC: begin
        alloc_tbl[proc][res]    = amount;
        alloc_loaded[proc][res] = 1'b1;
      end
      CMD_WR_MAX: begin
        claim_tbl[proc][res]    = amount;
        claim_loaded[proc][res] = 1'b1;
      end
      CMD_WR_AVAIL: begin
        avail_vec[res]    = amount;
        avail_loaded[res] = 1'b1;
      end
      default: predict_safe_sequence();
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned g;
    g = 0;
    while (g < 40 && $urandom_range(99) < idle_pct) g++;
    return g;
  endfunction

  // start is held high across back-to-back transactions and only dropped for a gap
  task automatic issue_command(input cmd_e cmd, input logic [PROC_W-1:0] proc,
                               input logic [RES_W-1:0] res,
                               input logic [AMOUNT_BITS-1:0] amount);
    repeat (next_gap) @(posedge clk_i);
    start            <= 1'b1;
    command_i        <= cmd;
    process_index_i  <= proc;
    resource_index_i <= res;
    amount_i         <= amount;
    start_held        = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    record_command(cmd, proc, res, amount);
    items_issued++;
    next_gap = pick_gap();
    if (next_gap != 0) begin
      start     <= 1'b0;
      start_held = 1'b0;
    end
  endtask

  task automatic wait_idle();
    if (start_held) begin
      start     <= 1'b0;
      start_held = 1'b0;
    end
    @(posedge clk_i);
    while (pending_results.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_counts(input logic [CFG_DATA_W-1:0] procs,
                              input logic [CFG_DATA_W-1:0] res);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_PROCESS_COUNT;
    cfg_data_i  <= procs;
    @(posedge clk_i);
    procs_reg    = procs[CNT_W-1:0];
    cfg_index_i <= CFG_RESOURCE_COUNT;
    cfg_data_i  <= res;
    @(posedge clk_i);
    res_reg   = res[RCNT_W-1:0];
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    if (idx == CFG_PROCESS_COUNT) procs_reg = value[CNT_W-1:0];
    else res_reg = value[RCNT_W-1:0];
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // every entry a run reads must have been written first
  task automatic load_missing();
    int unsigned np;
    int unsigned nr;
    np = procs_in_use();
    nr = res_in_use();
    for (int p = 0; p < np; p++) begin
      for (int r = 0; r < nr; r++) begin
        if (!alloc_loaded[p][r])
          issue_command(CMD_WR_ALLOC, PROC_W'(p), RES_W'(r), AMOUNT_BITS'($urandom_range(0, 7)));
        if (!claim_loaded[p][r])
          issue_command(CMD_WR_MAX, PROC_W'(p), RES_W'(r),
                        alloc_tbl[p][r] + AMOUNT_BITS'($urandom_range(0, 6)));
      end
    end
    for (int r = 0; r < nr; r++) begin
      if (!avail_loaded[r])
        issue_command(CMD_WR_AVAIL, PROC_W'($urandom), RES_W'(r),
                      AMOUNT_BITS'($urandom_range(0, 8)));
    end
  endtask

  task automatic run_check();
    load_missing();
    issue_command(CMD_RUN, PROC_W'($urandom), RES_W'($urandom), AMOUNT_BITS'($urandom));
  endtask

  // process count left at its reset value of 16
  task automatic test_reset_defaults();
    idle_pct = 0;
    write_reg(CFG_RESOURCE_COUNT, 5'd1);
    run_check();
    run_check();
  endtask

  task automatic test_directed();
    idle_pct = 0;
    write_counts(5'd2, 5'd2);
    issue_command(CMD_WR_ALLOC, 4'd0, 3'd0, 16'd3);
    issue_command(CMD_WR_ALLOC, 4'd0, 3'd1, 16'd1);
    issue_command(CMD_WR_ALLOC, 4'd1, 3'd0, 16'd4);
    issue_command(CMD_WR_ALLOC, 4'd1, 3'd1, 16'd2);
    issue_command(CMD_WR_MAX,   4'd0, 3'd0, 16'd9);
    issue_command(CMD_WR_MAX,   4'd0, 3'd1, 16'd4);
    issue_command(CMD_WR_MAX,   4'd1, 3'd0, 16'd6);
    issue_command(CMD_WR_MAX,   4'd1, 3'd1, 16'd2);
    issue_command(CMD_WR_AVAIL, 4'd0, 3'd0, 16'd2);
    issue_command(CMD_WR_AVAIL, 4'd0, 3'd1, 16'd1);
    // safe in order 1, 0; repeated run reuses the stored available vector
    run_check();
    run_check();
    // process 1 no longer fits: unsafe
    issue_command(CMD_WR_AVAIL, 4'd15, 3'd0, 16'd1);
    run_check();
    // allocation above maximum claim gives a negative need
    issue_command(CMD_WR_ALLOC, 4'd0, 3'd0, 16'hFFFF);
    issue_command(CMD_WR_ALLOC, 4'd0, 3'd1, 16'hFFFF);
    run_check();
    // rows and columns beyond the counts in use are stored but unused
    issue_command(CMD_WR_MAX,   4'd15, 3'd7, 16'hFFFF);
    issue_command(CMD_WR_ALLOC, 4'd15, 3'd7, 16'h5555);
    issue_command(CMD_WR_AVAIL, 4'd15, 3'd7, 16'hAAAA);
    run_check();
  endtask

  task automatic test_count_extremes();
    idle_pct = 0;
    write_counts(5'd0, 5'd16);
    run_check();
    write_counts(5'd1, 5'd8);
    run_check();
    write_counts(5'd16, 5'd1);
    run_check();
    write_counts(5'd31, 5'd1);
    run_check();
    write_counts(5'd1, 5'd31);
    run_check();
    write_counts(5'd17, 5'd1);
    run_check();
    write_counts(5'd1, 5'd9);
    run_check();
  endtask

  task automatic test_random_traffic(input int unsigned pct, input int unsigned n_items);
    int unsigned first;
    int unsigned pick;
    int unsigned np;
    int unsigned nr;
    int unsigned p;
    int unsigned r;
    first    = items_issued;
    idle_pct = pct;
    while (items_issued - first < n_items) begin
      pick = $urandom_range(99);
      np   = procs_in_use();
      nr   = res_in_use();
      if (pick < 8) begin
        if ($urandom_range(1)) write_counts(CFG_DATA_W'($urandom_range(0, 31)),
                                            CFG_DATA_W'($urandom_range(1, 2)));
        else if ($urandom_range(1)) write_counts(CFG_DATA_W'($urandom_range(1, 2)),
                                                 CFG_DATA_W'($urandom_range(0, 31)));
        else write_counts(CFG_DATA_W'($urandom_range(1, 6)), CFG_DATA_W'($urandom_range(1, 8)));
      end else if (pick < 18) begin
        repeat ($urandom_range(1, 4))
          issue_command(cmd_e'($urandom_range(0, 2)), PROC_W'($urandom), RES_W'($urandom),
                        AMOUNT_BITS'($urandom));
      end else begin
        repeat ($urandom_range(0, 5)) begin
          p = $urandom_range(0, np - 1);
          r = $urandom_range(0, nr - 1);
          case ($urandom_range(0, 2))
            0: issue_command(CMD_WR_ALLOC, PROC_W'(p), RES_W'(r),
                             AMOUNT_BITS'($urandom_range(0, 7)));
            1: begin
              if ($urandom_range(9) == 0)
                issue_command(CMD_WR_MAX, PROC_W'(p), RES_W'(r),
                              AMOUNT_BITS'($urandom_range(0, 3)));
              else
                issue_command(CMD_WR_MAX, PROC_W'(p), RES_W'(r),
                              (alloc_loaded[p][r] ? alloc_tbl[p][r] : '0)
                              + AMOUNT_BITS'($urandom_range(0, 6)));
            end
            default: issue_command(CMD_WR_AVAIL, PROC_W'($urandom), RES_W'(r),
                                   AMOUNT_BITS'($urandom_range(0, 8)));
          endcase
        end
        run_check();
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed();
    test_count_extremes();
    test_random_traffic(0, 60);
    test_random_traffic(54, 60);
    test_random_traffic(14, 50);
    wait_idle();
    repeat (40) @(posedge clk_i);
    if (pending_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (mismatch_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

### sim.f
src/bsc_pkg.sv
src/bsc_datapath.sv
src/bsc_ctrl.sv
src/bankers_safety_check_unit.sv
tb/sv/bankers_safety_check_unit_tb.sv
